/* rtl/core/rdkb_pkg.sv */
// Shared types and constants for the rolling dual-key byte decryptor.
// Used by every module under rtl/core; depends on nothing.
package rdkb_pkg;

  localparam int unsigned KeyNumW   = 7;
  localparam int unsigned PosW      = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned KeyW      = 128;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgAddrW  = 6;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [PosW-1:0] PosAStart = 4'd0;
  localparam logic [PosW-1:0] PosBStart = 4'd8;

  typedef enum logic [CmdW-1:0] {
    CMD_DECRYPT = 2'd0,
    CMD_SKIP    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_A_LOW  = 3'd0,
    REG_KEY_A_HIGH = 3'd1,
    REG_KEY_B_LOW  = 3'd2,
    REG_KEY_B_HIGH = 3'd3,
    REG_START_KEY  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [KeyNumW-1:0] key_number;
    logic [PosW-1:0]    position_a;
    logic [PosW-1:0]    position_b;
    logic               nibble_swap;
  } ks_state_t;

  typedef struct packed {
    logic [KeyW-1:0]    key_a;
    logic [KeyW-1:0]    key_b;
    logic [KeyNumW-1:0] start_key_number;
  } cfg_t;

endpackage

/* rtl/core/rolling_dual_key_byte_decryptor_unit.sv */
// Rolling dual-key byte decryptor, top level.
// Usage: load keys A and B and the start key number over APB (8-byte
//   registers at 0x00 key A low, 0x08 key A high, 0x10 key B low,
//   0x18 key B high, 0x20 start key number), then send a restart command.
// Input stream: tuser carries the command (decrypt, skip, restart) and
//   tdata the cipher byte. Output stream: tdata carries the plain byte,
//   one transfer per decrypt command, none for skip or restart.
// Output: a plain byte enters the output register at its input transfer.
//   Throughput: one byte per cycle while the output is taken; the keystream
//   update is a single register stage fed by position and key-number logic.
// Stall: the single output register holds a byte until taken; the input
//   stays ready while that register is empty or drains in the same cycle.
// Reset: synchronous rst clears the keys and start key number, and sets
//   key number 0, position A 0, position B 8, swap flag clear, output empty.
// Depends on rdkb_pkg, rdkb_regs, rdkb_keystream, rdkb_byte_path.
module rolling_dual_key_byte_decryptor_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] cipher_byte
  input  logic [rdkb_pkg::CmdW-1:0]       s_axis_tuser,  // [1:0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] plain_byte
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rdkb_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rdkb_pkg::CfgDataW-1:0]   pwdata,
  output logic [rdkb_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);
  import rdkb_pkg::*;

  cfg_t      cfg;
  ks_state_t state;
  logic      accept;

  assign accept = s_axis_tvalid & s_axis_tready;

  rdkb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rdkb_keystream u_keystream (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .command          (s_axis_tuser),
    .start_key_number (cfg.start_key_number),
    .state            (state)
  );

  rdkb_byte_path u_byte_path (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .command     (s_axis_tuser),
    .cipher_byte (s_axis_tdata),
    .state       (state),
    .key_a       (cfg.key_a),
    .key_b       (cfg.key_b),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .plain_byte  (m_axis_tdata)
  );

endmodule

/* rtl/core/rdkb_regs.sv */
// APB register file: keys A and B and the start key number.
// Depends on rdkb_pkg.
module rdkb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rdkb_pkg::CfgAddrW-1:0]    paddr,
  input  logic [rdkb_pkg::CfgDataW-1:0]    pwdata,
  output logic [rdkb_pkg::CfgDataW-1:0]    prdata,
  output logic                             pready,
  output rdkb_pkg::cfg_t                   cfg
);
  import rdkb_pkg::*;

  logic [CfgDataW-1:0] key_a_low;
  logic [CfgDataW-1:0] key_a_high;
  logic [CfgDataW-1:0] key_b_low;
  logic [CfgDataW-1:0] key_b_high;
  logic [KeyNumW-1:0]  start_key_number;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[CfgAddrW-1:CfgAddrW-CfgIdxW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a_low        <= '0;
      key_a_high       <= '0;
      key_b_low        <= '0;
      key_b_high       <= '0;
      start_key_number <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_KEY_A_LOW:  key_a_low        <= pwdata;
        REG_KEY_A_HIGH: key_a_high       <= pwdata;
        REG_KEY_B_LOW:  key_b_low        <= pwdata;
        REG_KEY_B_HIGH: key_b_high       <= pwdata;
        REG_START_KEY:  start_key_number <= pwdata[KeyNumW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KEY_A_LOW:  prdata = key_a_low;
      REG_KEY_A_HIGH: prdata = key_a_high;
      REG_KEY_B_LOW:  prdata = key_b_low;
      REG_KEY_B_HIGH: prdata = key_b_high;
      REG_START_KEY:  prdata = {{(CfgDataW-KeyNumW){1'b0}}, start_key_number};
      default:        prdata = '0;
    endcase
  end

  assign cfg.key_a            = {key_a_high, key_a_low};
  assign cfg.key_b            = {key_b_high, key_b_low};
  assign cfg.start_key_number = start_key_number;

endmodule

/* rtl/core/rdkb_keystream.sv */
// Keystream state: key number, key positions and swap flag, with the
// advance and restart rules. Depends on rdkb_pkg.
module rdkb_keystream (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [rdkb_pkg::CmdW-1:0]       command,
  input  logic [rdkb_pkg::KeyNumW-1:0]    start_key_number,
  output rdkb_pkg::ks_state_t             state
);
  import rdkb_pkg::*;

  // Octal digit folding, since 8 and 64 are 1 modulo 7.
  function automatic logic [2:0] mod7(input logic [KeyNumW-1:0] v);
    logic [3:0] s1;
    logic [3:0] s2;
    s1 = {3'b0, v[6]} + {1'b0, v[5:3]} + {1'b0, v[2:0]};
    s2 = {3'b0, s1[3]} + {1'b0, s1[2:0]};
    mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  // v mod 12 = 4 * ((v >> 2) mod 3) + (v mod 4).
  function automatic logic [3:0] mod12(input logic [KeyNumW-1:0] v);
    logic [4:0] q;
    logic [3:0] s1;
    logic [2:0] s2;
    logic [1:0] m3;
    q  = v[6:2];
    s1 = {1'b0, q[4:2]} + {2'b0, q[1:0]};
    s2 = {1'b0, s1[3:2]} + {1'b0, s1[1:0]};
    m3 = (s2 >= 3'd3) ? 2'(s2 - 3'd3) : s2[1:0];
    mod12 = {m3, v[1:0]};
  endfunction

  ks_state_t          adv;
  logic [KeyNumW-1:0] kn_next;
  logic [2:0]         kn_mod7;
  logic [3:0]         kn_mod12;

  always_comb begin
    kn_next  = state.key_number + KeyNumW'(2);
    kn_mod7  = mod7(kn_next);
    kn_mod12 = mod12(kn_next);
    adv      = state;
    adv.position_a = state.position_a + PosW'(1);
    adv.position_b = state.position_b + PosW'(1);
    if (state.position_a != 4'd15) begin
      if (state.position_b >= 4'd12) begin
        adv.position_b  = '0;
        adv.nibble_swap = ~state.nibble_swap;
      end
    end else if (state.position_b <= 4'd7) begin
      adv.position_a  = '0;
      adv.nibble_swap = ~state.nibble_swap;
    end else begin
      adv.key_number  = kn_next;
      adv.nibble_swap = ~state.nibble_swap;
      if (state.nibble_swap) begin
        adv.position_a = {1'b0, kn_mod7};
        adv.position_b = kn_mod12 + PosW'(2);
      end else begin
        adv.position_a = kn_mod12 + PosW'(3);
        adv.position_b = {1'b0, kn_mod7};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.key_number  <= '0;
      state.position_a  <= PosAStart;
      state.position_b  <= PosBStart;
      state.nibble_swap <= 1'b0;
    end else if (accept) begin
      case (cmd_t'(command))
        CMD_DECRYPT, CMD_SKIP: state <= adv;
        CMD_RESTART: begin
          state.key_number  <= start_key_number;
          state.position_a  <= PosAStart;
          state.position_b  <= PosBStart;
          state.nibble_swap <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/rdkb_byte_path.sv */
// Byte datapath: key byte selection, XOR and nibble swap, and the output
// register with its handshake. Depends on rdkb_pkg.
module rdkb_byte_path (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rdkb_pkg::CmdW-1:0]     command,
  input  logic [rdkb_pkg::ByteW-1:0]    cipher_byte,
  input  rdkb_pkg::ks_state_t           state,
  input  logic [rdkb_pkg::KeyW-1:0]     key_a,
  input  logic [rdkb_pkg::KeyW-1:0]     key_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rdkb_pkg::ByteW-1:0]    plain_byte
);
  import rdkb_pkg::*;

  logic [ByteW-1:0] key_a_byte;
  logic [ByteW-1:0] key_b_byte;
  logic [ByteW-1:0] mixed;
  logic [ByteW-1:0] swapped;
  logic [ByteW-1:0] plain_next;
  logic             load;

  assign in_ready   = ~out_valid | out_ready;
  assign load       = in_valid & in_ready & (cmd_t'(command) == CMD_DECRYPT);
  assign key_a_byte = key_a[{state.position_a, 3'b000} +: ByteW];
  assign key_b_byte = key_b[{state.position_b, 3'b000} +: ByteW];
  assign mixed      = cipher_byte ^ {1'b0, state.key_number} ^ key_b_byte;
  assign swapped    = state.nibble_swap ? {mixed[3:0], mixed[7:4]} : mixed;
  assign plain_next = swapped ^ key_a_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plain_byte <= plain_next;
    end
  end

endmodule

/* tb/rolling_dual_key_byte_decryptor_unit_tb.sv */
// Self-checking testbench for rolling_dual_key_byte_decryptor_unit: keys loaded over APB,
// byte commands streamed in, plain bytes compared with an in-bench keystream predictor.
// Depends on rdkb_pkg and the unit's RTL only.
module rolling_dual_key_byte_decryptor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdkb_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int ResetCycles = 4;
  localparam int PipeDrain = 4;
  localparam int HoldCycles = 300;
  localparam int WatchdogLimit = 3000;
  localparam int RandomPerPhase = 260;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned PosALast = 15;
  localparam int unsigned PosBLast = 12;
  localparam int unsigned PosBSplit = 8;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] cipher;
  } byte_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;       // [7:0] cipher_byte
  logic [CmdW-1:0] s_axis_tuser = '0;  // [1:0] command
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] plain_byte
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  rolling_dual_key_byte_decryptor_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #(HalfPeriod) clk = ~clk;

  byte_request_t pending_bytes[$];
  logic [ByteW-1:0] plain_expected[$];

  logic [KeyW-1:0] key_a_bytes = '0;
  logic [KeyW-1:0] key_b_bytes = '0;
  logic [KeyNumW-1:0] start_key = '0;
  logic [KeyNumW-1:0] ks_key_num = '0;
  logic [PosW-1:0] ks_pos_a = PosAStart;
  logic [PosW-1:0] ks_pos_b = PosBStart;
  logic ks_swap = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_orders = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int plain_checked = 0;
  int decrypts = 0;
  int skips = 0;
  int restarts = 0;
  int ignored = 0;
  int key_wraps = 0;
  int settings_loaded = 0;

  function automatic logic [ByteW-1:0] key_byte(logic [KeyW-1:0] k, logic [PosW-1:0] p);
    return k[{p, 3'b000} +: ByteW];
  endfunction

  function automatic logic [ByteW-1:0] plain_of(logic [ByteW-1:0] cipher);
    logic [ByteW-1:0] d;
    d = cipher ^ {1'b0, ks_key_num} ^ key_byte(key_b_bytes, ks_pos_b);
    if (ks_swap) d = {d[3:0], d[7:4]};
    return d ^ key_byte(key_a_bytes, ks_pos_a);
  endfunction

  task automatic advance_keystream();
    logic [4:0] a;
    logic [4:0] b;
    a = ks_pos_a + 5'd1;
    b = ks_pos_b + 5'd1;
    if (a <= PosALast) begin
      if (b > PosBLast) begin
        b = '0;
        ks_swap = ~ks_swap;
      end
    end else if (b <= PosBSplit) begin
      a = '0;
      ks_swap = ~ks_swap;
    end else begin
      if (ks_key_num > 7'd125) key_wraps++;
      ks_key_num = ks_key_num + 7'd2;
      if (ks_swap) begin
        ks_swap = 1'b0;
        a = 5'(ks_key_num % 7);
        b = 5'(ks_key_num % 12 + 2);
      end else begin
        ks_swap = 1'b1;
        a = 5'(ks_key_num % 12 + 3);
        b = 5'(ks_key_num % 7);
      end
    end
    ks_pos_a = a[PosW-1:0];
    ks_pos_b = b[PosW-1:0];
  endtask

  task automatic track_transfer(logic [CmdW-1:0] cmd, logic [ByteW-1:0] cipher);
    case (cmd)
      CMD_DECRYPT: begin
        plain_expected.push_back(plain_of(cipher));
        advance_keystream();
        decrypts++;
      end
      CMD_SKIP: begin
        advance_keystream();
        skips++;
      end
      CMD_RESTART: begin
        ks_key_num = start_key;
        ks_pos_a = PosAStart;
        ks_pos_b = PosBStart;
        ks_swap = 1'b0;
        restarts++;
      end
      default: ignored++;
    endcase
  endtask

  // sender: hold the offered byte until taken, then pick the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_transfer(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= pending_bytes[0].cmd;
          s_axis_tdata <= pending_bytes[0].cipher;
          void'(pending_bytes.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_orders) begin
      hold_served <= hold_orders;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : plain_monitor
    logic [ByteW-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (plain_expected.size() == 0) begin
        errors++;
        $display("%0t: plain byte with none pending: expected none, actual %02h",
                 $time, m_axis_tdata);
      end else begin
        want = plain_expected.pop_front();
        plain_checked++;
        if (m_axis_tdata !== want) begin
          errors++;
          $display("%0t: plain_byte mismatch: expected %02h, actual %02h",
                   $time, want, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < WatchdogLimit) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("%0t: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_A_LOW:  key_a_bytes[63:0] = value;
      REG_KEY_A_HIGH: key_a_bytes[127:64] = value;
      REG_KEY_B_LOW:  key_b_bytes[63:0] = value;
      REG_KEY_B_HIGH: key_b_bytes[127:64] = value;
      REG_START_KEY:  start_key = value[KeyNumW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [KeyW-1:0] ka, logic [KeyW-1:0] kb, logic [KeyNumW-1:0] sk);
    write_reg(REG_KEY_A_LOW, ka[63:0]);
    write_reg(REG_KEY_A_HIGH, ka[127:64]);
    write_reg(REG_KEY_B_LOW, kb[63:0]);
    write_reg(REG_KEY_B_HIGH, kb[127:64]);
    write_reg(REG_START_KEY, CfgDataW'(sk));
    settings_loaded++;
  endtask

  task automatic queue_byte(logic [CmdW-1:0] cmd, logic [ByteW-1:0] cipher);
    byte_request_t req;
    req.cmd = cmd;
    req.cipher = cipher;
    pending_bytes.push_back(req);
  endtask

  // restarts stay rare so the key number rolls far between them
  task automatic queue_random_run(int count);
    int queued;
    int unsigned r;
    queued = 0;
    queue_byte(CMD_RESTART, 8'($urandom));
    while (queued < count) begin
      r = $urandom_range(99);
      if (r < 72) queue_byte(CMD_DECRYPT, 8'($urandom_range(255)));
      else if (r < 96) queue_byte(CMD_SKIP, 8'($urandom_range(255)));
      else if (r < 97) queue_byte(CMD_RESTART, 8'($urandom_range(255)));
      else queue_byte(CMD_UNUSED, 8'($urandom_range(255)));
      if (r < 97) queued++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || s_axis_tvalid || plain_expected.size() != 0)
      @(negedge clk);
    repeat (PipeDrain) @(negedge clk);
  endtask

  function automatic logic [KeyW-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    logic [ByteW-1:0] edge_bytes[4];
    edge_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    queue_byte(CMD_DECRYPT, 8'h00);
    queue_byte(CMD_DECRYPT, 8'hFF);
    queue_byte(CMD_UNUSED, 8'hA5);
    queue_byte(CMD_SKIP, 8'h3C);
    wait_drained();

    load_settings(128'hF0E1D2C3B4A5968778695A4B3C2D1E0F,
                  128'h0123456789ABCDEFFEDCBA9876543210, 7'h7F);
    queue_byte(CMD_RESTART, 8'h00);
    for (int i = 0; i < 16; i++) queue_byte(CMD_DECRYPT, edge_bytes[i % 4]);
    queue_byte(CMD_SKIP, 8'hFF);
    queue_byte(CMD_UNUSED, 8'h5A);
    queue_byte(CMD_RESTART, 8'hFF);
    queue_byte(CMD_DECRYPT, 8'h81);
    wait_drained();

    load_settings(random_key(), random_key(), 7'($urandom_range(127)));
    send_idle_pct = 37;
    recv_idle_pct = 53;
    queue_random_run(RandomPerPhase);
    hold_orders++;
    wait_drained();

    load_settings('1, '1, 7'h7F);
    send_idle_pct = 53;
    recv_idle_pct = 37;
    queue_random_run(RandomPerPhase);
    wait_drained();

    load_settings(random_key(), random_key(), 7'h00);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_run(RandomPerPhase);
    wait_drained();

    $display("Covered %0d decrypts, %0d skips, %0d restarts, %0d ignored codes, %0d key settings",
             decrypts, skips, restarts, ignored, settings_loaded);
    $display("Checked %0d plain bytes; key number wrapped %0d times", plain_checked, key_wraps);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
